[rtl/dfe_pkg.sv]
// Shared constants and types of the delimited field extractor.
package dfe_pkg;

   // Largest delimiter the window can hold
   localparam int MAX_DELIM_BYTES = 8;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELIM_BYTES = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELIM_LEN   = 8'd1;

   // Register reset values
   localparam logic [63:0] DELIM_BYTES_RESET = 64'd44;
   localparam logic [3:0]  DELIM_LEN_RESET   = 4'd1;

   // Configuration as seen by the parser
   typedef struct packed {
      logic [63:0] delimiter_bytes;
      logic [3:0]  delimiter_length;
   } cfg_type;

   // Control part of one bundle of results handed from parser to output stage
   typedef struct packed {
      logic        has_final;
      logic        found;
      logic [15:0] field_length;
   } bundle_ctl_type;

endpackage

[rtl/dfe_if.sv]
// Channel interfaces of the delimited field extractor: request, response, register write.
interface dfe_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        end_of_record;
   logic [15:0] field_index;

   modport source (output valid, data_byte, end_of_record, field_index, input ready);
   modport sink   (input valid, data_byte, end_of_record, field_index, output ready);
endinterface

interface dfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        has_byte;
   logic        field_done;
   logic        found;
   logic [15:0] field_length;

   modport source (output valid, out_byte, has_byte, field_done, found, field_length,
                   input ready);
   modport sink   (input valid, out_byte, has_byte, field_done, found, field_length,
                   output ready);
endinterface

interface dfe_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dfe_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [63:0]                         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dfe_csr.sv]
// Configuration registers: delimiter bytes and delimiter length.
module dfe_csr (
   input  logic             clock,
   input  logic             reset,
   dfe_csr_if.sink          csr_bus,
   output dfe_pkg::cfg_type cfg
);

   logic [63:0] delim_bytes_ff, delim_bytes_in;
   logic [3:0]  delim_len_ff, delim_len_in;

   // Writes are always taken
   assign csr_bus.ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      delim_bytes_in = delim_bytes_ff;
      delim_len_in   = delim_len_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            dfe_pkg::CSR_DELIM_BYTES: delim_bytes_in = csr_bus.data;
            dfe_pkg::CSR_DELIM_LEN:   delim_len_in   = csr_bus.data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff <= dfe_pkg::DELIM_BYTES_RESET;
         delim_len_ff   <= dfe_pkg::DELIM_LEN_RESET;
      end else begin
         delim_bytes_ff <= delim_bytes_in;
         delim_len_ff   <= delim_len_in;
      end
   end

   assign cfg.delimiter_bytes  = delim_bytes_ff;
   assign cfg.delimiter_length = delim_len_ff;

endmodule

[rtl/dfe_parser.sv]
// Input register, delimiter window matching and record state; produces at most one result bundle per item.
module dfe_parser #(
   parameter int MAX_DELIM_BYTES = dfe_pkg::MAX_DELIM_BYTES,
   localparam int CW = $clog2(MAX_DELIM_BYTES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   dfe_req_if.sink                           req_bus,
   input  dfe_pkg::cfg_type                  cfg,
   output logic                              bun_load,
   input  logic                              bun_ready,
   output logic [MAX_DELIM_BYTES-1:0][7:0]   bun_bytes,
   output logic [CW-1:0]                     bun_count,
   output dfe_pkg::bundle_ctl_type           bun_ctl
);

   typedef enum logic [1:0] {PH_SKIP, PH_EMIT, PH_DONE} phase_type;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DELIM_BYTES);

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_eor_ff;
   logic [15:0] in_index_ff;

   // Record state
   logic [MAX_DELIM_BYTES-1:0][7:0] win_ff, win_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [15:0]                     passed_ff, passed_in;
   logic [15:0]                     wanted_ff, wanted_in;
   phase_type                       phase_ff, phase_in;
   logic [15:0]                     emitted_ff, emitted_in;
   logic                            at_start_ff, at_start_in;

   // Working values
   logic                            advance;
   logic [CW-1:0]                   cur_cnt;
   logic [15:0]                     cur_passed, cur_wanted, cur_emitted;
   phase_type                       cur_phase;
   logic [CW-1:0]                   eff_len;
   logic [MAX_DELIM_BYTES-1:0][7:0] nw, sw;
   logic [CW-1:0]                   nc, shift_n, hit_pos;
   logic [MAX_DELIM_BYTES-1:0]      cand;
   logic                            hit;

   function automatic logic [15:0] sat_len(input logic [15:0] a, input logic [CW-1:0] b);
      logic [16:0] s;
      s = {1'b0, a} + 17'(b);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   assign advance       = in_valid_ff && bun_ready;
   assign req_bus.ready = !in_valid_ff || bun_ready;

   // Input register refills whenever its item moves on
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) in_valid_in = req_bus.valid;
   end

   // State as seen by this item; a record's first item restarts it
   always_comb begin
      if (at_start_ff) begin
         cur_wanted  = in_index_ff;
         cur_passed  = 16'd0;
         cur_emitted = 16'd0;
         cur_cnt     = '0;
         cur_phase   = (in_index_ff == 16'd0) ? PH_EMIT : PH_SKIP;
      end else begin
         cur_wanted  = wanted_ff;
         cur_passed  = passed_ff;
         cur_emitted = emitted_ff;
         cur_cnt     = cnt_ff;
         cur_phase   = phase_ff;
      end
   end

   // Delimiter length clamped to 1..MAX
   always_comb begin
      if (cfg.delimiter_length == 4'd0) begin
         eff_len = CW'(1);
      end else if (int'(cfg.delimiter_length) > MAX_DELIM_BYTES) begin
         eff_len = MAX_CNT;
      end else begin
         eff_len = cfg.delimiter_length[CW-1:0];
      end
   end

   // Window with the new byte appended
   always_comb begin
      for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
         nw[j] = (CW'(j) == cur_cnt) ? in_byte_ff : win_ff[j];
      end
      nc = (cur_cnt < MAX_CNT) ? cur_cnt + CW'(1) : cur_cnt;
   end

   // Delimiter match at every start offset that has enough bytes
   always_comb begin
      for (int p = 0; p < MAX_DELIM_BYTES; p++) begin
         cand[p] = (p + int'(eff_len)) <= int'(nc);
         for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
            if ((i < int'(eff_len)) && (p + i < MAX_DELIM_BYTES)) begin
               if (nw[p + i] != cfg.delimiter_bytes[8*i +: 8]) cand[p] = 1'b0;
            end
         end
      end
      hit     = 1'b0;
      hit_pos = '0;
      for (int p = MAX_DELIM_BYTES - 1; p >= 0; p--) begin
         if (cand[p]) begin
            hit     = 1'b1;
            hit_pos = CW'(p);
         end
      end
   end

   // Bytes released ahead of a match, or all that can no longer start one
   always_comb begin
      if (hit) begin
         shift_n = hit_pos;
      end else if (nc >= eff_len) begin
         shift_n = nc - eff_len + CW'(1);
      end else begin
         shift_n = '0;
      end
      for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
         sw[j] = nw[j];
         for (int k = 0; k < MAX_DELIM_BYTES; k++) begin
            if ((CW'(k) == shift_n) && (j + k < MAX_DELIM_BYTES)) sw[j] = nw[j + k];
         end
      end
   end

   // Next state and the item's result bundle
   always_comb begin
      win_in      = win_ff;
      cnt_in      = cur_cnt;
      passed_in   = cur_passed;
      wanted_in   = cur_wanted;
      phase_in    = cur_phase;
      emitted_in  = cur_emitted;
      at_start_in = 1'b0;
      bun_bytes   = nw;
      bun_count   = '0;
      bun_ctl     = '0;

      if (in_eor_ff) begin
         // End of record: flush the window when emitting, then the final result
         bun_bytes           = win_ff;
         bun_count           = (cur_phase == PH_EMIT) ? cur_cnt : '0;
         bun_ctl.has_final   = 1'b1;
         bun_ctl.found       = (cur_phase != PH_SKIP);
         bun_ctl.field_length = (cur_phase != PH_SKIP) ? sat_len(cur_emitted, bun_count)
                                                      : 16'd0;
         cnt_in      = '0;
         at_start_in = 1'b1;
      end else if (cur_phase != PH_DONE) begin
         win_in = sw;
         cnt_in = hit ? '0 : nc - shift_n;
         if (cur_phase == PH_EMIT) begin
            bun_count  = shift_n;
            emitted_in = sat_len(cur_emitted, shift_n);
         end
         if (hit) begin
            case (cur_phase)
               PH_SKIP: begin
                  passed_in = cur_passed + 16'd1;
                  if (cur_passed + 16'd1 == cur_wanted) phase_in = PH_EMIT;
               end
               PH_EMIT: phase_in = PH_DONE;
               default: phase_in = cur_phase;
            endcase
         end
      end
   end

   assign bun_load = advance && ((bun_count != '0) || bun_ctl.has_final);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         passed_ff   <= 16'd0;
         wanted_ff   <= 16'd0;
         phase_ff    <= PH_SKIP;
         emitted_ff  <= 16'd0;
         at_start_ff <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            cnt_ff      <= cnt_in;
            passed_ff   <= passed_in;
            wanted_ff   <= wanted_in;
            phase_ff    <= phase_in;
            emitted_ff  <= emitted_in;
            at_start_ff <= at_start_in;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff  <= req_bus.data_byte;
         in_eor_ff   <= req_bus.end_of_record;
         in_index_ff <= req_bus.field_index;
      end
      if (advance) win_ff <= win_in;
   end

   // An end-of-record item always rearms the record start
   a_eor_rearm: assert property (@(posedge clock) disable iff (reset)
      advance && in_eor_ff |=> at_start_ff)
      else $error("record start not rearmed after end of record");

   // A closed field leaves nothing pending
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (cnt_ff == '0))
      else $error("window not empty after field closed");

endmodule

[rtl/dfe_out.sv]
// Result register: holds one bundle, hands out its items one per cycle while rsp_bus.ready.
module dfe_out #(
   parameter int MAX_DELIM_BYTES = dfe_pkg::MAX_DELIM_BYTES,
   localparam int CW = $clog2(MAX_DELIM_BYTES + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            bun_load,
   output logic                            bun_ready,
   input  logic [MAX_DELIM_BYTES-1:0][7:0] bun_bytes,
   input  logic [CW-1:0]                   bun_count,
   input  dfe_pkg::bundle_ctl_type         bun_ctl,
   dfe_rsp_if.source                       rsp_bus
);

   localparam int IW = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;

   logic                            valid_ff, valid_in;
   logic [CW-1:0]                   ptr_ff, ptr_in;
   logic [MAX_DELIM_BYTES-1:0][7:0] bytes_ff;
   logic [CW-1:0]                   count_ff;
   dfe_pkg::bundle_ctl_type         ctl_ff;

   logic [CW:0] total;
   logic        last, take, is_byte;

   // Item bookkeeping within the bundle
   assign total     = {1'b0, count_ff} + (CW+1)'(ctl_ff.has_final);
   assign last      = ({1'b0, ptr_ff} + (CW+1)'(1)) == total;
   assign take      = valid_ff && rsp_bus.ready;
   assign is_byte   = ptr_ff < count_ff;
   assign bun_ready = !valid_ff || (take && last);

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (bun_ready) begin
         valid_in = bun_load;
         ptr_in   = '0;
      end else if (take) begin
         ptr_in = ptr_ff + CW'(1);
      end
   end

   // Current item: a field byte or the final result
   always_comb begin
      rsp_bus.valid = valid_ff;
      if (is_byte) begin
         rsp_bus.out_byte     = bytes_ff[ptr_ff[IW-1:0]];
         rsp_bus.has_byte     = 1'b1;
         rsp_bus.field_done   = 1'b0;
         rsp_bus.found        = 1'b0;
         rsp_bus.field_length = 16'd0;
      end else begin
         rsp_bus.out_byte     = 8'd0;
         rsp_bus.has_byte     = 1'b0;
         rsp_bus.field_done   = 1'b1;
         rsp_bus.found        = ctl_ff.found;
         rsp_bus.field_length = ctl_ff.field_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bun_load && bun_ready) begin
         bytes_ff <= bun_bytes;
         count_ff <= bun_count;
         ctl_ff   <= bun_ctl;
      end
   end

   // Pointer stays inside the held bundle
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, ptr_ff} < total))
      else $error("result pointer past end of bundle");

   // Parser only loads when the register can take the bundle
   a_load_space: assert property (@(posedge clock) disable iff (reset)
      bun_load |-> bun_ready)
      else $error("bundle loaded while result register busy");

endmodule

[rtl/delimited_field_extractor.sv]
// Top level of the delimited field extractor.
//
// A record streams in on req_bus, one byte per item, and ends with an item
// whose end_of_record is set; field_index is sampled on the record's first
// item. rsp_bus returns the bytes of the selected field, one per item, and
// after them one final item with field_done, found and field_length.
// The delimiter (1 to 8 bytes) is set through csr_bus: index 0 holds the
// delimiter bytes, first byte in bits 7:0, index 1 the delimiter length.
// Write registers only between items.
// After an item is accepted, its first result passes the input register,
// then the result register, before it is valid on rsp_bus.
// Throughput: one item per cycle while each item yields at most one result
// and the receiver is ready. An item that yields k results (end-of-record
// flush, or a shortened delimiter) holds the result register until all k
// are taken; the input side keeps one item waiting meanwhile.
// When the receiver stalls, the result item holds and req_bus.ready falls
// once the input register is full.
// Reset restores delimiter "," of length 1 and starts a fresh record.
module delimited_field_extractor #(
   parameter int MAX_DELIM_BYTES = dfe_pkg::MAX_DELIM_BYTES
) (
   input logic        clock,
   input logic        reset,
   dfe_req_if.sink    req_bus,
   dfe_rsp_if.source  rsp_bus,
   dfe_csr_if.sink    csr_bus
);

   localparam int CW = $clog2(MAX_DELIM_BYTES + 1);

   dfe_pkg::cfg_type                cfg;
   logic                            bun_load;
   logic                            bun_ready;
   logic [MAX_DELIM_BYTES-1:0][7:0] bun_bytes;
   logic [CW-1:0]                   bun_count;
   dfe_pkg::bundle_ctl_type         bun_ctl;

   dfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   dfe_parser #(.MAX_DELIM_BYTES(MAX_DELIM_BYTES)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg),
      .bun_load  (bun_load),
      .bun_ready (bun_ready),
      .bun_bytes (bun_bytes),
      .bun_count (bun_count),
      .bun_ctl   (bun_ctl)
   );

   dfe_out #(.MAX_DELIM_BYTES(MAX_DELIM_BYTES)) u_out (
      .clock     (clock),
      .reset     (reset),
      .bun_load  (bun_load),
      .bun_ready (bun_ready),
      .bun_bytes (bun_bytes),
      .bun_count (bun_count),
      .bun_ctl   (bun_ctl),
      .rsp_bus   (rsp_bus)
   );

endmodule
